>>> rtl/ptce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptce_pkg
// Shared types, codes and constants for the PNG text chunk extractor.
// ----------------------------------------------------------------------------
package ptce_pkg;

    // chunk walk phases
    typedef enum logic [2:0] {
        PH_SIG    = 3'd0,
        PH_LEN    = 3'd1,
        PH_TYPE   = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4,
        PH_IGNORE = 3'd5
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // record end status codes
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_VALUE_ONLY = 2'd2;
    localparam logic [1:0] ST_DISCARD   = 2'd3;

    // chunk type words, big-endian
    localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
    localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;

    localparam logic [1:0] FIELD_LAST = 2'd3;
    localparam logic [2:0] SIG_LAST   = 3'd7;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } item_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       chunk_is_itxt;
        logic [1:0] end_status;
    } res_t;

    // expected file signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ptce_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptce_core
// Chunk walk state and per-item decode: updates the parse state for one
// byte and forms the result item it causes, if any.
// ----------------------------------------------------------------------------
module ptce_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  wire ptce_pkg::item_t item,
    output logic               res_valid,
    output ptce_pkg::res_t     res
);
    import ptce_pkg::*;

    logic [3:0]  sig_pos_reg,   sig_pos_next;
    phase_t      phase_reg,     phase_next;
    logic [1:0]  fbc_reg,       fbc_next;
    logic [31:0] len_reg,       len_next;
    logic [31:0] remain_reg,    remain_next;
    logic [31:0] type_reg,      type_next;
    logic        sep_reg,       sep_next;
    logic        is_text_reg,   is_text_next;

    // values after this byte, before the end-of-file reset
    logic [3:0]  sig_pos_step;
    phase_t      phase_step;
    logic [1:0]  fbc_step;
    logic [31:0] len_step;
    logic [31:0] remain_step;
    logic [31:0] type_step;
    logic        sep_step;
    logic        is_text_step;
    logic        crc_done;
    logic [7:0]  b;
    logic        fin;

    assign b   = item.in_byte;
    assign fin = item.in_final;

    // next state
    always_comb begin
        sig_pos_step = sig_pos_reg;
        phase_step   = phase_reg;
        fbc_step     = fbc_reg;
        len_step     = len_reg;
        remain_step  = remain_reg;
        type_step    = type_reg;
        sep_step     = sep_reg;
        is_text_step = is_text_reg;
        crc_done     = 1'b0;
        unique case (phase_reg)
            PH_SIG: begin
                if (b != sig_byte(sig_pos_reg[2:0])) begin
                    phase_step = PH_IGNORE;
                end else begin
                    sig_pos_step = sig_pos_reg + 4'd1;
                    if (sig_pos_reg[2:0] == SIG_LAST) begin
                        phase_step = PH_LEN;
                        fbc_step   = 2'd0;
                    end
                end
            end
            PH_LEN: begin
                len_step = {len_reg[23:0], b};
                if (fbc_reg == FIELD_LAST) begin
                    fbc_step   = 2'd0;
                    phase_step = PH_TYPE;
                end else begin
                    fbc_step = fbc_reg + 2'd1;
                end
            end
            PH_TYPE: begin
                type_step = {type_reg[23:0], b};
                if (fbc_reg == FIELD_LAST) begin
                    fbc_step     = 2'd0;
                    is_text_step = (type_step == TYPE_TEXT) || (type_step == TYPE_ITXT);
                    sep_step     = 1'b0;
                    remain_step  = len_reg;
                    phase_step   = (len_reg == 32'd0) ? PH_CRC : PH_DATA;
                end else begin
                    fbc_step = fbc_reg + 2'd1;
                end
            end
            PH_DATA: begin
                if (is_text_reg && !fin && !sep_reg && (b == 8'd0)) begin
                    sep_step = 1'b1;
                end
                remain_step = remain_reg - 32'd1;
                if (remain_reg == 32'd1) begin
                    phase_step = PH_CRC;
                end
            end
            PH_CRC: begin
                if (fbc_reg == FIELD_LAST) begin
                    fbc_step     = 2'd0;
                    crc_done     = 1'b1;
                    is_text_step = 1'b0;
                    len_step     = 32'd0;
                    type_step    = 32'd0;
                    sep_step     = 1'b0;
                    phase_step   = PH_LEN;
                end else begin
                    fbc_step = fbc_reg + 2'd1;
                end
            end
            default: begin
                phase_step = PH_IGNORE;
            end
        endcase

        // end of file returns everything to the reset state
        if (fin) begin
            sig_pos_next = 4'd0;
            phase_next   = PH_SIG;
            fbc_next     = 2'd0;
            len_next     = 32'd0;
            remain_next  = 32'd0;
            type_next    = 32'd0;
            sep_next     = 1'b0;
            is_text_next = 1'b0;
        end else begin
            sig_pos_next = sig_pos_step;
            phase_next   = phase_step;
            fbc_next     = fbc_step;
            len_next     = len_step;
            remain_next  = remain_step;
            type_next    = type_step;
            sep_next     = sep_step;
            is_text_next = is_text_step;
        end
    end

    // result item for this byte
    always_comb begin
        res_valid         = 1'b0;
        res.out_byte      = 8'd0;
        res.out_kind      = KIND_KEY;
        res.end_status    = ST_NONE;
        res.chunk_is_itxt = (phase_reg == PH_TYPE) ? (type_step == TYPE_ITXT)
                                                   : (type_reg == TYPE_ITXT);
        unique case (phase_reg)
            PH_DATA: begin
                if (is_text_reg && !fin) begin
                    if (sep_reg) begin
                        res_valid    = 1'b1;
                        res.out_byte = b;
                        res.out_kind = KIND_VALUE;
                    end else if (b != 8'd0) begin
                        res_valid    = 1'b1;
                        res.out_byte = b;
                        res.out_kind = KIND_KEY;
                    end
                end
            end
            PH_CRC: begin
                if ((fbc_reg == FIELD_LAST) && is_text_reg) begin
                    res_valid      = 1'b1;
                    res.out_kind   = KIND_END;
                    res.end_status = sep_reg ? ST_COMPLETE : ST_VALUE_ONLY;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        // file ends inside a text chunk
        if (fin && !crc_done && is_text_step &&
            ((phase_step == PH_DATA) || (phase_step == PH_CRC))) begin
            res_valid      = 1'b1;
            res.out_byte   = 8'd0;
            res.out_kind   = KIND_END;
            res.end_status = ST_DISCARD;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_pos_reg <= 4'd0;
            phase_reg   <= PH_SIG;
            fbc_reg     <= 2'd0;
            len_reg     <= 32'd0;
            remain_reg  <= 32'd0;
            type_reg    <= 32'd0;
            sep_reg     <= 1'b0;
            is_text_reg <= 1'b0;
        end else if (fire) begin
            sig_pos_reg <= sig_pos_next;
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
            type_reg    <= type_next;
            sep_reg     <= sep_next;
            is_text_reg <= is_text_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/png_text_chunk_extractor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// png_text_chunk_extractor_unit
// Streaming PNG tEXt/iTXt extractor: emits key bytes, value bytes and a
// record end for each text chunk of a byte-wide PNG file stream.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and can produce one result per
// cycle while the output is not stalled. An accepted byte lands in an input
// register; the chunk walk logic decodes it from there and the result, if
// any, is loaded into the output register, from which it is presented.
// Backpressure on m_tready stalls the input register only when the output
// register is full and not being taken. Bytes that cause no result
// (signature, lengths, types, CRCs, other chunks) are absorbed.
module png_text_chunk_extractor_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // in_final
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [4:0]      m_tuser    // [1:0] out_kind, [2] chunk_is_itxt, [4:3] end_status
);
    import ptce_pkg::*;

    logic   in_valid_reg, in_valid_next;
    item_t  in_item_reg;
    logic   core_fire;
    logic   res_valid;
    res_t   res;
    logic   out_valid_reg, out_valid_next;
    res_t   out_res_reg;

    // handshake between the stages
    assign core_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (core_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (core_fire) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.in_byte  <= s_tdata;
            in_item_reg.in_final <= s_tlast;
        end
    end

    // chunk walk
    ptce_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (core_fire),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_byte;
    assign m_tuser  = {out_res_reg.end_status, out_res_reg.chunk_is_itxt,
                       out_res_reg.out_kind};

    // record ends carry no text byte
    a_end_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == KIND_END)) |-> (m_tdata == 8'd0))
        else $error("record end with nonzero byte");

    // text bytes carry no end status
    a_text_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != KIND_END)) |-> (m_tuser[4:3] == ST_NONE))
        else $error("text byte with end status");

    // the separator NUL is never sent as a key byte
    a_key_not_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == KIND_KEY)) |-> (m_tdata != 8'd0))
        else $error("NUL sent as key byte");

endmodule
`default_nettype wire

>>> tb/sv/png_text_chunk_extractor_unit_tb.sv
// ----------------------------------------------------------------------------
// png_text_chunk_extractor_unit_tb
// Feeds PNG byte streams into the text chunk extractor and checks every
// key, value and record-end item against a cycle-free predictor of the
// chunk walk. Directed files cover text records, bad signatures, empty
// chunks, truncated files and huge lengths; random files follow, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module png_text_chunk_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptce_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_BYTES  = 200;
    localparam int MAX_PRINTS    = 50;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;

    png_text_chunk_extractor_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),    // in_final
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte
        .m_tuser  (m_tuser)     // [1:0] out_kind, [2] chunk_is_itxt, [4:3] end_status
    );

    localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                             8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

    // predicted chunk walk state
    logic [3:0]  sig_pos;
    phase_t      walk_phase;
    logic [1:0]  fld_cnt;
    logic [31:0] chunk_len;
    logic [31:0] data_left;
    logic [31:0] chunk_type;
    logic        sep_seen;
    logic        in_text;

    res_t        text_results_q [$];
    logic [7:0]  file_bytes [$];

    bit          idle_on = 1'b1;
    int          error_count = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          cycle_count = 0;

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_walk();
        sig_pos    = '0;
        walk_phase = PH_SIG;
        fld_cnt    = '0;
        chunk_len  = '0;
        data_left  = '0;
        chunk_type = '0;
        sep_seen   = 1'b0;
        in_text    = 1'b0;
    endfunction

    function automatic void add_text_result(input logic [7:0] b, input logic [1:0] kind,
                                            input logic [1:0] status);
        res_t r;
        r.out_byte      = b;
        r.out_kind      = kind;
        r.chunk_is_itxt = (chunk_type == TYPE_ITXT);
        r.end_status    = status;
        text_results_q = {text_results_q, r};
    endfunction

    function automatic void walk_chunk_byte(input logic [7:0] b, input logic fin);
        logic closed;
        closed = 1'b0;
        case (walk_phase)
            PH_SIG: begin
                if (b != PNG_MAGIC[sig_pos[2:0]]) begin
                    walk_phase = PH_IGNORE;
                end else begin
                    sig_pos = sig_pos + 4'd1;
                    if (sig_pos >= 4'd8) begin
                        walk_phase = PH_LEN;
                        fld_cnt    = '0;
                    end
                end
            end
            PH_LEN: begin
                chunk_len = {chunk_len[23:0], b};
                if (fld_cnt == FIELD_LAST) begin
                    fld_cnt    = '0;
                    walk_phase = PH_TYPE;
                end else begin
                    fld_cnt = fld_cnt + 2'd1;
                end
            end
            PH_TYPE: begin
                chunk_type = {chunk_type[23:0], b};
                if (fld_cnt == FIELD_LAST) begin
                    fld_cnt   = '0;
                    in_text   = (chunk_type == TYPE_TEXT) || (chunk_type == TYPE_ITXT);
                    sep_seen  = 1'b0;
                    data_left = chunk_len;
                    if (chunk_len == 32'd0)
                        walk_phase = PH_CRC;
                    else
                        walk_phase = PH_DATA;
                end else begin
                    fld_cnt = fld_cnt + 2'd1;
                end
            end
            PH_DATA: begin
                // first NUL splits key from value and is not passed on
                if (in_text && !fin) begin
                    if (sep_seen)
                        add_text_result(b, KIND_VALUE, ST_NONE);
                    else if (b == 8'h00)
                        sep_seen = 1'b1;
                    else
                        add_text_result(b, KIND_KEY, ST_NONE);
                end
                data_left = data_left - 32'd1;
                if (data_left == 32'd0)
                    walk_phase = PH_CRC;
            end
            PH_CRC: begin
                if (fld_cnt == FIELD_LAST) begin
                    fld_cnt = '0;
                    if (in_text)
                        add_text_result(8'h00, KIND_END,
                                        sep_seen ? ST_COMPLETE : ST_VALUE_ONLY);
                    closed     = 1'b1;
                    in_text    = 1'b0;
                    chunk_len  = '0;
                    chunk_type = '0;
                    sep_seen   = 1'b0;
                    walk_phase = PH_LEN;
                end else begin
                    fld_cnt = fld_cnt + 2'd1;
                end
            end
            default: walk_phase = PH_IGNORE;
        endcase

        // file ends inside an open text chunk: drop the record
        if (fin) begin
            if (!closed && in_text && (walk_phase == PH_DATA || walk_phase == PH_CRC))
                add_text_result(8'h00, KIND_END, ST_DISCARD);
            clear_walk();
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        walk_chunk_byte(b, fin);
        bytes_sent++;
    endtask

    // sends the assembled file, final flag on its last byte
    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    // appends one byte to the file under construction
    task automatic add_file_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_file_byte(w[8*i +: 8]);
    endtask

    task automatic put_signature();
        for (int i = 0; i < 8; i++)
            add_file_byte(PNG_MAGIC[i]);
    endtask

    task automatic cut_file(input int keep);
        while (file_bytes.size() > keep)
            void'(file_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, compare with the oldest expectation
    // ------------------------------------------------------------------
    initial begin
        res_t want;
        int   stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            if (text_results_q.size() == 0) begin
                report($sformatf("unexpected item byte=%02h user=%02h", m_tdata, m_tuser));
            end else begin
                want = text_results_q.pop_front();
                if (m_tdata !== want.out_byte)
                    report($sformatf("out_byte %02h, want %02h", m_tdata, want.out_byte));
                if (m_tuser[1:0] !== want.out_kind)
                    report($sformatf("out_kind %0d, want %0d", m_tuser[1:0], want.out_kind));
                if (m_tuser[2] !== want.chunk_is_itxt)
                    report($sformatf("chunk_is_itxt %0b, want %0b", m_tuser[2],
                                     want.chunk_is_itxt));
                if (m_tuser[4:3] !== want.end_status)
                    report($sformatf("end_status %0d, want %0d", m_tuser[4:3],
                                     want.end_status));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // complete records: key/value split, no separator, empty chunk, other chunk
    task automatic test_text_records();
        put_signature();
        put_word(32'd5);
        put_word(TYPE_TEXT);
        add_file_byte(8'h01);
        add_file_byte(8'hFF);
        add_file_byte(8'h00);
        add_file_byte(8'hFF);
        add_file_byte(8'h00);    // later NUL is value data
        put_word(32'hFFFF_FFFF);
        put_word(32'd2);
        put_word(TYPE_ITXT);
        add_file_byte(8'h41);
        add_file_byte(8'h42);
        put_word(32'h0000_0000);
        put_word(32'd0);                // empty text chunk
        put_word(TYPE_TEXT);
        put_word(32'h1234_5678);
        put_word(32'd2);
        put_word(TYPE_IDAT);
        add_file_byte(8'h00);
        add_file_byte(8'h55);
        put_word(32'hA5A5_5A5A);
        send_file();
    endtask

    // a wrong signature byte silences the whole file
    task automatic test_bad_signature();
        put_signature();
        file_bytes[1] = 8'h51;
        put_word(32'd1);
        put_word(TYPE_TEXT);
        add_file_byte(8'h61);
        put_word(32'd0);
        send_file();
        add_file_byte(8'h00);
        add_file_byte(8'h89);
        send_file();
    endtask

    // final byte at several places of a file
    task automatic test_truncated_files();
        // on the last type byte of a text chunk
        put_signature();
        put_word(32'd3);
        put_word(TYPE_TEXT);
        send_file();
        // inside text data
        put_signature();
        put_word(32'd4);
        put_word(TYPE_ITXT);
        add_file_byte(8'h61);
        add_file_byte(8'h62);
        send_file();
        // inside the CRC of a text chunk
        put_signature();
        put_word(32'd2);
        put_word(TYPE_TEXT);
        add_file_byte(8'h00);
        add_file_byte(8'h7A);
        put_word(32'hDEAD_BEEF);
        cut_file(file_bytes.size() - 2);
        send_file();
        // inside a non-text chunk
        put_signature();
        put_word(32'd4);
        put_word(TYPE_IDAT);
        add_file_byte(8'h33);
        send_file();
        // inside the signature and inside a length field
        put_signature();
        cut_file(3);
        send_file();
        put_signature();
        put_word(32'd7);
        cut_file(10);
        send_file();
        // on the last signature byte
        put_signature();
        send_file();
    endtask

    // all-ones length; file ends long before the data would
    task automatic test_huge_length();
        put_signature();
        put_word(32'hFFFF_FFFF);
        put_word(TYPE_TEXT);
        add_file_byte(8'h78);
        add_file_byte(8'h00);
        add_file_byte(8'h79);
        add_file_byte(8'h80);
        send_file();
    endtask

    // mostly well-formed files with random content, some broken, some noise
    task automatic test_random_files();
        int          start;
        int          mode;
        int          nchunks;
        int          pick;
        int          len;
        bit          huge;
        logic [31:0] ctype;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            mode    = $urandom_range(0, 9);
            huge    = 1'b0;
            if (mode == 0) begin
                // noise, sometimes starting like a signature
                if ($urandom_range(0, 1) == 1)
                    add_file_byte(8'h89);
                repeat ($urandom_range(1, 10))
                    add_file_byte(8'($urandom));
            end else begin
                put_signature();
                if (mode == 1)
                    file_bytes[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
                nchunks = $urandom_range(1, 4);
                for (int c = 0; c < nchunks && !huge; c++) begin
                    pick = $urandom_range(0, 5);
                    case (pick)
                        0, 1:    ctype = TYPE_TEXT;
                        2, 3:    ctype = TYPE_ITXT;
                        4:       ctype = $urandom;
                        default: ctype = (($urandom_range(0, 1) == 1) ? TYPE_TEXT : TYPE_ITXT)
                                         ^ (32'd1 << $urandom_range(0, 31));
                    endcase
                    huge = ($urandom_range(0, 9) == 0);
                    if (huge) begin
                        put_word($urandom | 32'h8000_0000);
                        put_word(ctype);
                        repeat ($urandom_range(1, 6))
                            add_file_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                                      : 8'($urandom));
                    end else begin
                        len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                        put_word(len);
                        put_word(ctype);
                        repeat (len)
                            add_file_byte(($urandom_range(0, 3) == 0) ? 8'h00
                                                                      : 8'($urandom));
                        put_word($urandom);
                    end
                end
                if (!huge && $urandom_range(0, 2) == 0)
                    cut_file($urandom_range(1, file_bytes.size()));
            end
            send_file();
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        clear_walk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_text_records();
        test_bad_signature();
        test_truncated_files();
        test_huge_length();
        test_random_files();
        s_tvalid <= 1'b0;

        // let the last results drain
        waited = 0;
        while (text_results_q.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (text_results_q.size() != 0)
            report($sformatf("%0d expected items never arrived", text_results_q.size()));

        $display("ran %0d files, %0d bytes, %0d result items checked", files_sent,
                 bytes_sent, results_seen);
        $display("covered text records, bad signatures, truncation, huge lengths, random files");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ptce_pkg.sv
rtl/ptce_core.sv
rtl/png_text_chunk_extractor_unit.sv
tb/sv/png_text_chunk_extractor_unit_tb.sv
